[rtl/ssrs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrs_pkg
// Shared types and constants for the sorted set rank/select block.
// ----------------------------------------------------------------------------
package ssrs_pkg;

    // Flip the sign bit so that unsigned order matches signed order.
    localparam logic [31:0] SIGN_BIAS   = 32'h8000_0000;
    localparam logic [31:0] MISS_ANSWER = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_RANK   = 2'd2,
        MODE_KTH    = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH,
        ST_SRCH_CMP,
        ST_INS_CHK,
        ST_INS_WR,
        ST_DEL_CHK,
        ST_DEL_WR,
        ST_KTH,
        ST_RESULT
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;       // capture the request, open the search window
        logic rd_mid;     // read the probe entry
        logic cmp;        // narrow the search window
        logic idx_count;  // point the shift index at the count
        logic idx_lo;     // point the shift index at the lower bound
        logic ins_rd;     // read entry idx-1
        logic ins_wr;     // write it to idx, step down
        logic ins_put;    // write the new key, bump the count
        logic del_rd;     // read entry idx+1
        logic del_wr;     // write it to idx, step up
        logic del_done;   // drop the count
        logic kth_rd;     // read entry k-1
        logic emit;       // load the response register
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        mode_t mode;
        logic  lo_lt_hi;
        logic  hit;
        logic  full;
        logic  ins_more;
        logic  del_more;
        logic  kth_ok;
        logic  out_free;
    } sts_t;

endpackage

[rtl/ssrs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrs_ctrl
// Sequencer: binary search, shift loops, k-th read and response hand-off.
// ----------------------------------------------------------------------------
module ssrs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [1:0]        req_mode,
    input  ssrs_pkg::sts_t    sts,
    output ssrs_pkg::cmd_t    cmd,
    output logic              busy
);
    import ssrs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    if (mode_t'(req_mode) == MODE_KTH)
                    begin
                        state_next = ST_KTH;
                    end
                    else
                    begin
                        state_next = ST_SRCH;
                    end
                end
            end
            ST_SRCH:
            begin
                if (sts.lo_lt_hi)
                begin
                    cmd.rd_mid = 1'b1;
                    state_next = ST_SRCH_CMP;
                end
                else
                begin
                    case (sts.mode)
                        MODE_INSERT:
                        begin
                            if (sts.hit || sts.full)
                            begin
                                state_next = ST_IDLE;
                            end
                            else
                            begin
                                cmd.idx_count = 1'b1;
                                state_next    = ST_INS_CHK;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (sts.hit)
                            begin
                                cmd.idx_lo = 1'b1;
                                state_next = ST_DEL_CHK;
                            end
                            else
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                        MODE_RANK:
                        begin
                            state_next = ST_RESULT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SRCH_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = ST_SRCH;
            end
            ST_INS_CHK:
            begin
                if (sts.ins_more)
                begin
                    cmd.ins_rd = 1'b1;
                    state_next = ST_INS_WR;
                end
                else
                begin
                    cmd.ins_put = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_INS_WR:
            begin
                cmd.ins_wr = 1'b1;
                state_next = ST_INS_CHK;
            end
            ST_DEL_CHK:
            begin
                if (sts.del_more)
                begin
                    cmd.del_rd = 1'b1;
                    state_next = ST_DEL_WR;
                end
                else
                begin
                    cmd.del_done = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DEL_WR:
            begin
                cmd.del_wr = 1'b1;
                state_next = ST_DEL_CHK;
            end
            ST_KTH:
            begin
                cmd.kth_rd = sts.kth_ok;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/ssrs_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrs_dpath
// Key store, count, search window, shift index and response register.
// ----------------------------------------------------------------------------
module ssrs_dpath #(
    parameter int DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          req_mode,
    input  logic signed [31:0]  req_value,
    input  ssrs_pkg::cmd_t      cmd,
    output ssrs_pkg::sts_t      sts,
    input  logic                rsp_stall,
    output logic                rsp_valid,
    output logic signed [31:0]  rsp_answer,
    output logic                rsp_found
);
    import ssrs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [31:0]   key_mem [DEPTH];

    mode_t         mode_reg;
    logic [31:0]   key_reg;
    logic [CW-1:0] lo_reg;
    logic [CW-1:0] hi_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] count_reg;
    logic          hit_reg;
    logic [31:0]   rd_data_reg;
    logic          out_valid_reg;
    logic [31:0]   answer_reg;
    logic          found_reg;

    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    logic [31:0]   raw;
    logic [CW-1:0] kth_idx;
    logic [CW-1:0] rd_idx;
    logic [CW-1:0] wr_idx;
    logic [31:0]   wr_data;
    logic          mem_re;
    logic          mem_we;
    logic          kth_ok;
    logic          out_free;
    logic [31:0]   answer_next;
    logic          found_next;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CW:1];
    assign raw     = key_reg ^ SIGN_BIAS;
    assign kth_idx = raw[CW-1:0] - CW'(1);
    assign kth_ok  = !raw[31] && (raw != 32'd0) && (raw <= 32'(count_reg));
    assign out_free = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        rd_idx = mid;
        if (cmd.ins_rd)
        begin
            rd_idx = idx_reg - CW'(1);
        end
        else if (cmd.del_rd)
        begin
            rd_idx = idx_reg + CW'(1);
        end
        else if (cmd.kth_rd)
        begin
            rd_idx = kth_idx;
        end
    end

    assign mem_re  = cmd.rd_mid | cmd.ins_rd | cmd.del_rd | cmd.kth_rd;
    assign mem_we  = cmd.ins_wr | cmd.del_wr | cmd.ins_put;
    assign wr_idx  = cmd.ins_put ? lo_reg : idx_reg;
    assign wr_data = cmd.ins_put ? key_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[wr_idx[AW-1:0]] <= wr_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= key_mem[rd_idx[AW-1:0]];
        end
    end

    // Search window, shift index and request capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode_t'(req_mode);
            key_reg  <= req_value ^ SIGN_BIAS;
            lo_reg   <= '0;
            hi_reg   <= count_reg;
            hit_reg  <= 1'b0;
        end
        else if (cmd.cmp)
        begin
            if (rd_data_reg < key_reg)
            begin
                lo_reg <= mid + CW'(1);
            end
            else
            begin
                hi_reg <= mid;
            end
            if (rd_data_reg == key_reg)
            begin
                hit_reg <= 1'b1;
            end
        end

        if (cmd.idx_count)
        begin
            idx_reg <= count_reg;
        end
        else if (cmd.idx_lo)
        begin
            idx_reg <= lo_reg;
        end
        else if (cmd.ins_wr)
        begin
            idx_reg <= idx_reg - CW'(1);
        end
        else if (cmd.del_wr)
        begin
            idx_reg <= idx_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.ins_put)
        begin
            count_reg <= count_reg + CW'(1);
        end
        else if (cmd.del_done)
        begin
            count_reg <= count_reg - CW'(1);
        end
    end

    always_comb
    begin
        if (mode_reg == MODE_RANK)
        begin
            found_next  = hit_reg;
            answer_next = hit_reg ? (32'(lo_reg) + 32'd1) : MISS_ANSWER;
        end
        else
        begin
            found_next  = kth_ok;
            answer_next = kth_ok ? (rd_data_reg ^ SIGN_BIAS) : MISS_ANSWER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            answer_reg <= answer_next;
            found_reg  <= found_next;
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign rsp_answer = answer_reg;
    assign rsp_found  = found_reg;

    assign sts.mode     = mode_reg;
    assign sts.lo_lt_hi = lo_reg < hi_reg;
    assign sts.hit      = hit_reg;
    assign sts.full     = count_reg == CW'(DEPTH);
    assign sts.ins_more = idx_reg > lo_reg;
    assign sts.del_more = ({1'b0, idx_reg} + (CW + 1)'(1)) < {1'b0, count_reg};
    assign sts.kth_ok   = kth_ok;
    assign sts.out_free = out_free;

endmodule

[rtl/sorted_set_rank_select.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_rank_select
// Order-statistic set of distinct signed 32-bit keys kept sorted in a RAM.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------
//  req     | in        | req_valid / req_stall | mode[1:0], value[31:0]
//  rsp     | out       | rsp_valid / rsp_stall | answer[31:0], found
//
// One request is worked at a time; req_stall is high from the cycle after
// acceptance until the request finishes. The single-port key RAM sets the
// pace: each search probe is a read then a compare, and each key moved by
// an insert or delete is a read then a write back. Insert: search, move the
// keys above up, write the new key (skipped on a hit or a full set).
// Delete: search, move the keys above down, drop the count (skipped on a
// miss). Rank: search, respond. K-th: read entry k-1, respond.
// Reset clears the count, the sequencer state and the response valid flag
// but not the RAM; no clearing pass is needed, as entries at or above the
// count are never read. A finished response sits in an output register; a
// stall on rsp holds it, and a new request is still taken while it waits. A
// query reaching its last step while the register is held waits until it frees.
//
// mode: insert, delete, rank query, k-th smallest query. Queries give one
// response each; insert and delete give none.
// ----------------------------------------------------------------------------
module sorted_set_rank_select #(
    parameter int DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [1:0]         mode,
    input  logic signed [31:0] value,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic signed [31:0] answer,
    output logic               found
);
    import ssrs_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic busy;

    // Sequencer: owns the state machine only.
    ssrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_mode  (mode),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy)
    );

    // Datapath: key RAM, count, search window and response register.
    ssrs_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_mode   (mode),
        .req_value  (value),
        .cmd        (cmd),
        .sts        (sts),
        .rsp_stall  (rsp_stall),
        .rsp_valid  (rsp_valid),
        .rsp_answer (answer),
        .rsp_found  (found)
    );

    // Take a request only while the sequencer is idle.
    assign req_stall = busy;

endmodule

[rtl/ssrs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrs_checker
// Port-level checks for sorted_set_rank_select, bound to the top level.
// ----------------------------------------------------------------------------
module ssrs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input logic signed [31:0] answer,
    input logic               found
);

    // Hold a stalled response.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(answer) && $stable(found))
        else $error("stalled response changed");

    // Every accepted request occupies the block: req_stall is high in the cycle after acceptance.
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("block free right after a request");

    // A miss always carries the miss answer.
    a_miss_val: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !found |-> answer == -32'sd1)
        else $error("miss without -1 answer");

    // A response appears only out of a request in progress.
    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("response without a request in progress");

endmodule

bind sorted_set_rank_select ssrs_checker u_ssrs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .answer    (answer),
    .found     (found)
);
